/* design/collation_element_parse_pack_assert.svh */
// assertion macros shared by the collation element checker
`ifndef COLLATION_ELEMENT_PARSE_PACK_ASSERT_SVH
`define COLLATION_ELEMENT_PARSE_PACK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CEPP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CEPP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/cepp_pkg.sv */
// shared types and constants of the collation element parser
`default_nettype none

package cepp_pkg;

	localparam int MaxUnits = 16;

	typedef enum logic [1:0] {
		StUnit      = 2'd0,
		StMalformed = 2'd1,
		StSecTooBig = 2'd2,
		StTooMany   = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] primary;
		logic [7:0]  secondary;
		logic [7:0]  tertiary;
		logic        is_variable;
		status_t     status;
		logic        last_unit;
		logic [15:0] max_variable;
	} res_t;

	// everything one character produces: zero, one or two results
	typedef struct packed {
		logic [1:0]       count;
		res_t [1:0]       res;
	} step_out_t;

endpackage

`default_nettype wire

/* design/cepp_parse.sv */
// character scanner and element packer with the per-record state
`default_nettype none

module cepp_parse #(
	parameter int MAX_UNITS = cepp_pkg::MaxUnits
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          ch,
	input  wire logic                line_end,
	output cepp_pkg::step_out_t      so
);

	localparam int CntW = $clog2(MAX_UNITS);
	localparam logic [CntW-1:0] UnitLimit = CntW'(MAX_UNITS - 1);

	localparam logic [7:0] ChOpen  = 8'h5B;
	localparam logic [7:0] ChClose = 8'h5D;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChHash  = 8'h23;

	localparam logic [15:0] PrimEscape = 16'hFE00;
	localparam logic [15:0] SecRebase  = 16'h001F;
	localparam logic [15:0] SecDirect  = 16'h011D;
	localparam logic [15:0] SecLimit   = 16'h0127;
	localparam logic [15:0] SecExtBase = 16'h0100;
	localparam logic [7:0]  SecEscape  = 8'hFF;

	typedef enum logic [2:0] {
		PhOutside   = 3'd0,
		PhOpen      = 3'd1,
		PhPrimary   = 3'd2,
		PhSecondary = 3'd3,
		PhTertiary  = 3'd4
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [15:0]     acc_q, acc_d;
	logic [2:0]      digits_q, digits_d;
	logic            var_q, var_d;
	logic [15:0]     held_p_q, held_p_d;
	logic [15:0]     held_s_q, held_s_d;
	logic [CntW-1:0] units_q, units_d;
	logic [15:0]     maxv_q, maxv_d;
	logic            comment_q, comment_d;

	logic            d_ok;
	logic [3:0]      d_val;
	logic [7:0]      closer;
	logic            do_out, do_bad, do_fin;
	logic [15:0]     pw, pext, sec_reb, sec_ext;
	logic [7:0]      sw, sext;
	logic            need_ext;
	logic [1:0]      n;
	cepp_pkg::res_t  r;
	cepp_pkg::res_t [1:0] res;

	// hex digit decode
	always_comb begin
		d_ok  = 1'b1;
		d_val = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			d_val = 4'(ch - 8'h30);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			d_val = 4'(ch - 8'h57);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			d_val = 4'(ch - 8'h37);
		end else begin
			d_ok = 1'b0;
		end
	end

	// packed weights of the element being closed
	always_comb begin
		sec_reb = held_s_q - SecRebase;
		sec_ext = held_s_q - SecExtBase;
		pext    = 16'd0;
		sext    = 8'd0;
		if (held_p_q < PrimEscape) begin
			pw = held_p_q;
		end else begin
			pw   = PrimEscape;
			pext = held_p_q - PrimEscape + 16'd1;
		end
		if (held_s_q == 16'd0) begin
			sw = 8'd0;
		end else if (held_s_q <= SecDirect) begin
			sw = sec_reb[7:0];
		end else begin
			sw   = SecEscape;
			sext = sec_ext[7:0];
		end
		need_ext = (pext != 16'd0) || (sext != 8'd0);
	end

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		digits_d  = digits_q;
		var_d     = var_q;
		held_p_d  = held_p_q;
		held_s_d  = held_s_q;
		units_d   = units_q;
		maxv_d    = maxv_q;
		comment_d = comment_q;
		do_out    = 1'b0;
		do_bad    = 1'b0;
		do_fin    = 1'b0;
		closer    = (phase_q == PhTertiary) ? ChClose : ChDot;
		n         = 2'd0;
		res       = '0;
		r         = '0;

		if (!comment_q) begin
			case (phase_q)
				PhOutside: begin
					do_out = 1'b1;
				end
				PhOpen: begin
					if (ch == ChStar || ch == ChDot) begin
						var_d    = (ch == ChStar);
						phase_d  = PhPrimary;
						acc_d    = '0;
						digits_d = '0;
					end else begin
						do_bad = 1'b1;
					end
				end
				PhPrimary, PhSecondary, PhTertiary: begin
					if (d_ok && digits_q < 3'd4) begin
						acc_d    = {acc_q[11:0], d_val};
						digits_d = digits_q + 3'd1;
					end else if (ch == closer) begin
						case (phase_q)
							PhPrimary: begin
								held_p_d = acc_q;
								phase_d  = PhSecondary;
							end
							PhSecondary: begin
								held_s_d = acc_q;
								phase_d  = PhTertiary;
							end
							default: begin
								do_fin  = 1'b1;
								phase_d = PhOutside;
							end
						endcase
						acc_d    = '0;
						digits_d = '0;
					end else begin
						do_bad = 1'b1;
					end
				end
				default: begin
					phase_d = PhOutside;
				end
			endcase

			// bad character: report, then rescan it as an outside character
			if (do_bad) begin
				r        = '0;
				r.status = cepp_pkg::StMalformed;
				res[n[0]] = r;
				n        = n + 2'd1;
				phase_d  = PhOutside;
				do_out   = 1'b1;
			end

			if (do_out) begin
				if (ch == ChOpen) begin
					phase_d  = PhOpen;
					acc_d    = '0;
					digits_d = '0;
				end else if (ch == ChHash) begin
					comment_d = 1'b1;
				end
			end

			if (do_fin) begin
				if (var_q && held_p_q > maxv_q) begin
					maxv_d = held_p_q;
				end
				if (held_s_q > SecLimit) begin
					r             = '0;
					r.is_variable = var_q;
					r.status      = cepp_pkg::StSecTooBig;
					res[n[0]]     = r;
					n             = n + 2'd1;
				end else begin
					r             = '0;
					r.primary     = pw;
					r.secondary   = sw;
					r.tertiary    = acc_q[7:0];
					r.is_variable = var_q;
					if (units_d < UnitLimit) begin
						units_d  = units_d + 1'b1;
						r.status = cepp_pkg::StUnit;
					end else begin
						r.status = cepp_pkg::StTooMany;
					end
					res[n[0]] = r;
					n         = n + 2'd1;
					if (need_ext) begin
						r             = '0;
						r.primary     = pext;
						r.secondary   = sext;
						r.is_variable = var_q;
						if (units_d < UnitLimit) begin
							units_d  = units_d + 1'b1;
							r.status = cepp_pkg::StUnit;
						end else begin
							r.status = cepp_pkg::StTooMany;
						end
						res[n[0]] = r;
						n         = n + 2'd1;
					end
				end
			end
		end

		// record end: flag an open element, then clear per-record state
		if (line_end) begin
			if (phase_d != PhOutside && n < 2'd2) begin
				r        = '0;
				r.status = cepp_pkg::StMalformed;
				res[n[0]] = r;
				n        = n + 2'd1;
			end
			phase_d   = PhOutside;
			acc_d     = '0;
			digits_d  = '0;
			var_d     = 1'b0;
			held_p_d  = '0;
			held_s_d  = '0;
			units_d   = '0;
			comment_d = 1'b0;
		end

		res[0].last_unit    = (n == 2'd1);
		res[1].last_unit    = (n == 2'd2);
		res[0].max_variable = maxv_d;
		res[1].max_variable = maxv_d;
	end

	assign so.count = n;
	assign so.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PhOutside;
			acc_q     <= '0;
			digits_q  <= '0;
			var_q     <= 1'b0;
			held_p_q  <= '0;
			held_s_q  <= '0;
			units_q   <= '0;
			maxv_q    <= '0;
			comment_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			digits_q  <= digits_d;
			var_q     <= var_d;
			held_p_q  <= held_p_d;
			held_s_q  <= held_s_d;
			units_q   <= units_d;
			maxv_q    <= maxv_d;
			comment_q <= comment_d;
		end
	end

endmodule

`default_nettype wire

/* design/collation_element_parse_pack.sv */
// top level of the collation element parser and packer
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | ch, line_end
//  out     | out_valid / out_stall| primary_out, secondary_out, tertiary_out,
//          |                      | is_variable, status, last_unit,
//          |                      | max_variable_primary
//
// one character per cycle while in_stall is low; as a character leaves the input
// register, its results are written into the output buffer, whose head is on the out port
// a character that closes an element with an extension unit gives two results, which
// leave one per cycle through the two-entry output buffer while out_stall is low
// arst_n clears the scanner state, the maximum variable primary and both buffers
// out_stall backs up through the output buffer into the input register and
// then raises in_stall; nothing is dropped
`default_nettype none

module collation_element_parse_pack #(
	parameter int MAX_UNITS = cepp_pkg::MaxUnits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      primary_out,
	output logic [7:0]       secondary_out,
	output logic [7:0]       tertiary_out,
	output logic             is_variable,
	output logic [1:0]       status,
	output logic             last_unit,
	output logic [15:0]      max_variable_primary
);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       line_end_s1;

	// output buffer: head is shown on the port, tail waits behind it
	cepp_pkg::res_t head_q, tail_q;
	logic [1:0]     occ_q;

	cepp_pkg::step_out_t so;
	logic                pop;
	logic [1:0]          occ_left;
	logic [1:0]          free;
	logic                step;

	cepp_parse #(
		.MAX_UNITS (MAX_UNITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ch       (ch_s1),
		.line_end (line_end_s1),
		.so       (so)
	);

	assign pop      = out_valid && !out_stall;
	assign occ_left = occ_q - {1'b0, pop};
	assign free     = 2'd2 - occ_left;
	// the character in the input register moves on once its results fit
	assign step     = valid_s1 && (so.count <= free);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register, loaded with every acceptance
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1       <= ch;
			line_end_s1 <= line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_left + (step ? so.count : 2'd0);
		end
	end

	// buffer payload: keep what is left after the pop, append new results
	always_ff @(posedge clk) begin
		case (occ_left)
			2'd0: begin
				head_q <= so.res[0];
				tail_q <= so.res[1];
			end
			2'd1: begin
				head_q <= pop ? tail_q : head_q;
				tail_q <= so.res[0];
			end
			default: begin
				head_q <= head_q;
				tail_q <= tail_q;
			end
		endcase
	end

	assign out_valid            = (occ_q != 2'd0);
	assign primary_out          = head_q.primary;
	assign secondary_out        = head_q.secondary;
	assign tertiary_out         = head_q.tertiary;
	assign is_variable          = head_q.is_variable;
	assign status               = head_q.status;
	assign last_unit            = head_q.last_unit;
	assign max_variable_primary = head_q.max_variable;

endmodule

`default_nettype wire

/* design/cepp_checker.sv */
// port-level checks of the collation element parser, bound to the top level
`default_nettype none

`include "collation_element_parse_pack_assert.svh"

module cepp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] primary_out,
	input wire logic [7:0]  secondary_out,
	input wire logic [7:0]  tertiary_out,
	input wire logic        is_variable,
	input wire logic [1:0]  status,
	input wire logic [15:0] max_variable_primary
);

	`CEPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(primary_out) && $stable(status), "result item changed while stalled")

	`CEPP_ASSERT_NOW(a_malformed_zero, out_valid && status == cepp_pkg::StMalformed, primary_out == 16'd0 && secondary_out == 8'd0 && tertiary_out == 8'd0 && !is_variable, "malformed item carries weights")

	`CEPP_ASSERT_NOW(a_toobig_zero, out_valid && status == cepp_pkg::StSecTooBig, primary_out == 16'd0 && secondary_out == 8'd0 && tertiary_out == 8'd0, "oversized secondary item carries weights")

	`CEPP_ASSERT_NEXT(a_max_rises, out_valid && !out_stall, !out_valid || max_variable_primary >= $past(max_variable_primary), "maximum variable primary went down")

endmodule

bind collation_element_parse_pack cepp_checker u_cepp_checker (.*);

`default_nettype wire
